/* design/bnle_pkg.sv */
package bnle_pkg;

  typedef enum logic [1:0] {
    ROLE_READER = 2'd0,
    ROLE_VOTER  = 2'd1,
    ROLE_LEADER = 2'd2
  } role_t;

  // Event kinds
  localparam logic [3:0] K_STARTUP   = 4'd0;
  localparam logic [3:0] K_BUSIDLE   = 4'd1;
  localparam logic [3:0] K_HBTMO     = 4'd2;
  localparam logic [3:0] K_RANDOM    = 4'd3;
  localparam logic [3:0] K_COUNTING  = 4'd4;
  localparam logic [3:0] K_HEARTBEAT = 4'd5;
  localparam logic [3:0] K_SENSOR    = 4'd6;
  localparam logic [3:0] K_WTF       = 4'd7;
  localparam logic [3:0] K_VOTING    = 4'd8;

  // Actions
  localparam logic [2:0] A_NONE      = 3'd0;
  localparam logic [2:0] A_CLEAR_ALL = 3'd1;
  localparam logic [2:0] A_CLEAR_ONE = 3'd2;
  localparam logic [2:0] A_ARM       = 3'd3;
  localparam logic [2:0] A_SEND      = 3'd4;

  // Timers
  localparam logic [1:0] T_BUSIDLE   = 2'd0;
  localparam logic [1:0] T_COUNTING  = 2'd1;
  localparam logic [1:0] T_RANDOM    = 2'd2;
  localparam logic [1:0] T_HEARTBEAT = 2'd3;

  // Messages
  localparam logic [1:0] M_HEARTBEAT = 2'd0;
  localparam logic [1:0] M_SENSOR    = 2'd1;
  localparam logic [1:0] M_WTF       = 2'd2;
  localparam logic [1:0] M_VOTING    = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_OWN_ID    = 2'd0;
  localparam logic [1:0] CFG_BUS_IDLE  = 2'd1;
  localparam logic [1:0] CFG_COUNTING  = 2'd2;
  localparam logic [1:0] CFG_HEARTBEAT = 2'd3;

  localparam logic [5:0]  OWN_ID_RST    = 6'd1;
  localparam logic [15:0] BUS_IDLE_RST  = 16'd500;
  localparam logic [15:0] COUNTING_RST  = 16'd150;
  localparam logic [15:0] HEARTBEAT_RST = 16'd100;

  // Random delay is draw % 29 + 1; quotient by reciprocal, exact for 16-bit draws
  localparam logic [4:0]  RND_MOD    = 5'd29;
  localparam logic [16:0] RND_RECIP  = 17'd72316;   // ceil(2^21 / 29)
  localparam int          QUOT_W     = 12;

  localparam int RES_SLOTS = 3;

  typedef struct packed {
    logic [2:0]  action;
    logic [1:0]  timer_sel;
    logic [15:0] delay;
    logic [5:0]  dest_id;
    logic [1:0]  message;
    logic [5:0]  message_param;
    logic        ignored;
    logic        last;
  } res_t;

  function automatic res_t mk_res(logic [2:0] action, logic [1:0] tsel,
                                  logic [15:0] delay, logic [5:0] dest,
                                  logic [1:0] msg, logic [5:0] param, logic ign);
    res_t r;
    r.action        = action;
    r.timer_sel     = tsel;
    r.delay         = delay;
    r.dest_id       = dest;
    r.message       = msg;
    r.message_param = param;
    r.ignored       = ign;
    r.last          = 1'b0;
    return r;
  endfunction

endpackage

/* design/bnle_decide.sv */
module bnle_decide #(
  parameter int VOTER_BITS = 32
) (
  input  bnle_pkg::role_t            role,
  input  logic [5:0]                 last_leader_id,
  input  logic [VOTER_BITS-1:0]      seen_voters,
  input  logic [5:0]                 own_id,
  input  logic [15:0]                bus_idle_ticks,
  input  logic [15:0]                counting_ticks,
  input  logic [15:0]                heartbeat_ticks,
  input  logic [3:0]                 kind,
  input  logic [5:0]                 sender_id,
  input  logic [15:0]                random_draw,
  input  logic [bnle_pkg::QUOT_W-1:0] rnd_quot,
  output bnle_pkg::role_t            role_next,
  output logic [5:0]                 last_leader_id_next,
  output logic [VOTER_BITS-1:0]      seen_voters_next,
  output bnle_pkg::res_t             res [bnle_pkg::RES_SLOTS],
  output logic [1:0]                 res_cnt
);
  import bnle_pkg::*;

  localparam logic [VOTER_BITS-1:0] ONE = VOTER_BITS'(1);

  logic [15:0]           quot_x29;
  logic [15:0]           rnd_rem;
  logic [15:0]           rnd_delay;
  logic                  vote_in_range;
  logic [VOTER_BITS-1:0] vote_bit;
  logic                  own_in_range;
  logic [VOTER_BITS-1:0] own_bit;
  logic                  many_voters;
  logic                  win;
  res_t                  r0, r1, r2;
  logic [1:0]            n;
  logic                  ign;

  // Remainder from the registered quotient: q*29 = q*32 - q*2 - q
  assign quot_x29  = (16'(rnd_quot) << 5) - (16'(rnd_quot) << 1) - 16'(rnd_quot);
  assign rnd_rem   = random_draw - quot_x29;
  assign rnd_delay = 16'(rnd_rem[4:0]) + 16'd1;

  assign vote_in_range = (sender_id != 6'd0) && (sender_id <= 6'(VOTER_BITS));
  assign vote_bit      = ONE << (sender_id - 6'd1);

  // Win: at least two voters, and the lowest equals own id: own bit set and nothing below it
  assign own_in_range = (own_id != 6'd0) && (own_id <= 6'(VOTER_BITS));
  assign own_bit      = ONE << (own_id - 6'd1);
  assign many_voters  = (seen_voters & (seen_voters - ONE)) != '0;
  assign win = many_voters && own_in_range && ((seen_voters & own_bit) != '0)
               && ((seen_voters & (own_bit - ONE)) == '0);

  always_comb begin
    role_next = role;
    case (role)
      ROLE_READER: begin
        if (kind == K_BUSIDLE) role_next = ROLE_VOTER;
      end
      ROLE_VOTER: begin
        if (kind == K_COUNTING) role_next = win ? ROLE_LEADER : ROLE_READER;
        else if (kind == K_HEARTBEAT) role_next = ROLE_READER;
      end
      ROLE_LEADER: begin
        if (kind == K_WTF) role_next = ROLE_READER;
      end
      default: role_next = role;
    endcase
  end

  always_comb begin
    r0 = '0;
    r1 = '0;
    r2 = '0;
    n = 2'd0;
    ign = 1'b0;
    last_leader_id_next = last_leader_id;
    seen_voters_next = seen_voters;
    case (role)
      ROLE_READER: begin
        case (kind)
          K_STARTUP: begin
            r0 = mk_res(A_CLEAR_ALL, T_BUSIDLE, '0, '0, M_HEARTBEAT, '0, 1'b0);
            r1 = mk_res(A_ARM, T_BUSIDLE, bus_idle_ticks, '0, M_HEARTBEAT, '0, 1'b0);
            n = 2'd2;
          end
          K_BUSIDLE: begin
            r0 = mk_res(A_CLEAR_ALL, T_BUSIDLE, '0, '0, M_HEARTBEAT, '0, 1'b0);
            r1 = mk_res(A_ARM, T_COUNTING, counting_ticks, '0, M_HEARTBEAT, '0, 1'b0);
            r2 = mk_res(A_ARM, T_RANDOM, rnd_delay, '0, M_HEARTBEAT, '0, 1'b0);
            n = 2'd3;
            seen_voters_next = '0;
          end
          K_HEARTBEAT: begin
            if (sender_id <= last_leader_id || last_leader_id == 6'd0) begin
              last_leader_id_next = sender_id;
              r0 = mk_res(A_CLEAR_ONE, T_BUSIDLE, '0, '0, M_HEARTBEAT, '0, 1'b0);
              r1 = mk_res(A_ARM, T_BUSIDLE, bus_idle_ticks, '0, M_HEARTBEAT, '0, 1'b0);
              n = 2'd2;
            end
          end
          K_SENSOR: begin
            r0 = mk_res(A_SEND, T_BUSIDLE, '0, last_leader_id, M_SENSOR, '0, 1'b0);
            n = 2'd1;
          end
          default: ign = 1'b1;
        endcase
      end
      ROLE_VOTER: begin
        case (kind)
          K_COUNTING: begin
            r0 = mk_res(A_CLEAR_ALL, T_BUSIDLE, '0, '0, M_HEARTBEAT, '0, 1'b0);
            if (win) begin
              r1 = mk_res(A_ARM, T_HEARTBEAT, heartbeat_ticks, '0, M_HEARTBEAT, '0, 1'b0);
            end else begin
              r1 = mk_res(A_ARM, T_BUSIDLE, bus_idle_ticks, '0, M_HEARTBEAT, '0, 1'b0);
              last_leader_id_next = 6'd0;
            end
            n = 2'd2;
          end
          K_RANDOM: begin
            r0 = mk_res(A_SEND, T_BUSIDLE, '0, 6'd0, M_VOTING, own_id, 1'b0);
            r1 = mk_res(A_ARM, T_RANDOM, rnd_delay, '0, M_HEARTBEAT, '0, 1'b0);
            n = 2'd2;
          end
          K_HEARTBEAT: begin
            r0 = mk_res(A_CLEAR_ALL, T_BUSIDLE, '0, '0, M_HEARTBEAT, '0, 1'b0);
            r1 = mk_res(A_ARM, T_BUSIDLE, bus_idle_ticks, '0, M_HEARTBEAT, '0, 1'b0);
            n = 2'd2;
            last_leader_id_next = 6'd0;
          end
          K_SENSOR: n = 2'd0;
          K_VOTING: begin
            if (!vote_in_range) begin
              ign = 1'b1;
            end else if ((seen_voters & vote_bit) == '0) begin
              seen_voters_next = seen_voters | vote_bit;
              r0 = mk_res(A_CLEAR_ONE, T_COUNTING, '0, '0, M_HEARTBEAT, '0, 1'b0);
              r1 = mk_res(A_ARM, T_COUNTING, counting_ticks, '0, M_HEARTBEAT, '0, 1'b0);
              n = 2'd2;
            end
          end
          default: ign = 1'b1;
        endcase
      end
      ROLE_LEADER: begin
        case (kind)
          K_HBTMO: begin
            r0 = mk_res(A_SEND, T_BUSIDLE, '0, 6'd0, M_HEARTBEAT, own_id, 1'b0);
            r1 = mk_res(A_ARM, T_HEARTBEAT, heartbeat_ticks, '0, M_HEARTBEAT, '0, 1'b0);
            n = 2'd2;
          end
          K_HEARTBEAT: begin
            if (sender_id > own_id) begin
              r0 = mk_res(A_SEND, T_BUSIDLE, '0, sender_id, M_WTF, '0, 1'b0);
              n = 2'd1;
            end
          end
          K_SENSOR: n = 2'd0;
          K_WTF: begin
            r0 = mk_res(A_CLEAR_ALL, T_BUSIDLE, '0, '0, M_HEARTBEAT, '0, 1'b0);
            r1 = mk_res(A_ARM, T_BUSIDLE, bus_idle_ticks, '0, M_HEARTBEAT, '0, 1'b0);
            n = 2'd2;
            last_leader_id_next = 6'd0;
          end
          default: ign = 1'b1;
        endcase
      end
      default: ign = 1'b1;
    endcase

    // An event with no action still yields one result
    if (n == 2'd0) begin
      r0 = mk_res(A_NONE, T_BUSIDLE, '0, '0, M_HEARTBEAT, '0, ign);
      n = 2'd1;
    end
    r0.last = (n == 2'd1);
    r1.last = (n == 2'd2);
    r2.last = (n == 2'd3);
  end

  assign res[0]  = r0;
  assign res[1]  = r1;
  assign res[2]  = r2;
  assign res_cnt = n;

endmodule

/* design/bnle_burst.sv */
module bnle_burst (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  bnle_pkg::res_t res [bnle_pkg::RES_SLOTS],
  input  logic [1:0]     res_cnt,
  output logic           can_load,
  output logic           out_valid,
  input  logic           out_ready,
  output bnle_pkg::res_t head
);
  import bnle_pkg::*;

  res_t       slots [RES_SLOTS];
  logic [1:0] cnt;
  logic       take;

  assign out_valid = (cnt != 2'd0);
  assign take      = out_valid && out_ready;
  // Refill when empty, or when the final result leaves in this cycle
  assign can_load  = (cnt == 2'd0) || (cnt == 2'd1 && out_ready);
  assign head      = slots[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= res_cnt;
    end else if (take) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= res;
    end else if (take) begin
      slots[0] <= slots[1];
      slots[1] <= slots[2];
    end
  end

endmodule

/* design/bus_node_leader_election.sv */
// A result appears once its event has passed the input register, then the
// three-slot result buffer; further results follow one per cycle while
// out_ready is high. An event yields one to three results and holds the result
// buffer until all have left; the input register takes a new event meanwhile.
// Reset (synchronous, active high): role reader, no leader, no voters seen,
// registers at their defaults, input register and result buffer empty.
module bus_node_leader_election #(
  parameter int NODES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  kind,
  input  logic [5:0]  sender_id,
  input  logic [15:0] random_draw,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  action,
  output logic [1:0]  timer_sel,
  output logic [15:0] delay,
  output logic [5:0]  dest_id,
  output logic [1:0]  message,
  output logic [5:0]  message_param,
  output logic        ignored,
  output logic        last
);
  import bnle_pkg::*;

  // The voter bitmap covers ids 1..NODES, at most 32 of them
  localparam int VOTER_BITS = (NODES < 32) ? NODES : 32;

  // Configuration registers
  logic [5:0]  own_id;
  logic [15:0] bus_idle_ticks;
  logic [15:0] counting_ticks;
  logic [15:0] heartbeat_ticks;

  // Election state
  role_t                 role;
  logic [5:0]            last_leader_id;
  logic [VOTER_BITS-1:0] seen_voters;
  role_t                 role_next;
  logic [5:0]            last_leader_id_next;
  logic [VOTER_BITS-1:0] seen_voters_next;

  // Input register
  logic                  iv;
  logic [3:0]            kind_q;
  logic [5:0]            sender_id_q;
  logic [15:0]           random_draw_q;
  logic [QUOT_W-1:0]     rnd_quot;
  logic [32:0]           quot_prod;

  res_t       res [RES_SLOTS];
  logic [1:0] res_cnt;
  logic       can_load;
  logic       load;
  res_t       head;

  // The user must write configuration only while idle (not enforced here); take every transfer at once
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id          <= OWN_ID_RST;
      bus_idle_ticks  <= BUS_IDLE_RST;
      counting_ticks  <= COUNTING_RST;
      heartbeat_ticks <= HEARTBEAT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_OWN_ID:    own_id          <= cfg_data[5:0];
        CFG_BUS_IDLE:  bus_idle_ticks  <= cfg_data;
        CFG_COUNTING:  counting_ticks  <= cfg_data;
        CFG_HEARTBEAT: heartbeat_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Divide the random draw by 29 on the way in; the remainder is formed
  // from the registered quotient.
  assign quot_prod = 33'(random_draw) * 33'(RND_RECIP);

  // Hand the registered event to the result buffer once it can take all
  // results; accept a new event in the same cycle.
  assign load     = iv && can_load;
  assign in_ready = !iv || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (in_valid && in_ready) begin
      iv <= 1'b1;
    end else if (load) begin
      iv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_q        <= kind;
      sender_id_q   <= sender_id;
      random_draw_q <= random_draw;
      rnd_quot      <= quot_prod[32:21];
    end
  end

  // Advance the election state with each event handed to the buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      role           <= ROLE_READER;
      last_leader_id <= 6'd0;
      seen_voters    <= '0;
    end else if (load) begin
      role           <= role_next;
      last_leader_id <= last_leader_id_next;
      seen_voters    <= seen_voters_next;
    end
  end

  bnle_decide #(
    .VOTER_BITS(VOTER_BITS)
  ) u_decide (
    .role                (role),
    .last_leader_id      (last_leader_id),
    .seen_voters         (seen_voters),
    .own_id              (own_id),
    .bus_idle_ticks      (bus_idle_ticks),
    .counting_ticks      (counting_ticks),
    .heartbeat_ticks     (heartbeat_ticks),
    .kind                (kind_q),
    .sender_id           (sender_id_q),
    .random_draw         (random_draw_q),
    .rnd_quot            (rnd_quot),
    .role_next           (role_next),
    .last_leader_id_next (last_leader_id_next),
    .seen_voters_next    (seen_voters_next),
    .res                 (res),
    .res_cnt             (res_cnt)
  );

  bnle_burst u_burst (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .res       (res),
    .res_cnt   (res_cnt),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign action        = head.action;
  assign timer_sel     = head.timer_sel;
  assign delay         = head.delay;
  assign dest_id       = head.dest_id;
  assign message       = head.message;
  assign message_param = head.message_param;
  assign ignored       = head.ignored;
  assign last          = head.last;

`ifndef SYNTH
  // A handed-over event always shows a result in the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid)
    else $error("result buffer empty after load");

  // A registered event is not dropped before it is handed over
  a_hold_event: assert property (@(posedge clk) disable iff (rst)
    iv && !load |=> iv && $stable(kind_q) && $stable(sender_id_q))
    else $error("pending event lost or changed");

  // Entering voter starts with an empty voter bitmap
  a_voter_clear: assert property (@(posedge clk) disable iff (rst)
    $rose(role == ROLE_VOTER) |-> seen_voters == '0)
    else $error("voter bitmap not cleared on entry to voter");

  // Leadership is reached only from voter
  a_leader_from_voter: assert property (@(posedge clk) disable iff (rst)
    $rose(role == ROLE_LEADER) |-> $past(role) == ROLE_VOTER)
    else $error("leader entered from a role other than voter");
`endif

endmodule

/* tb/bnle_tb_pkg.sv */
package bnle_tb_pkg;
  import bnle_pkg::*;

  localparam int VOTER_SLOTS = 32;

  class election_scoreboard;
    role_t       role;
    logic [5:0]  leader_id;
    logic [31:0] voters;
    logic [5:0]  own_id;
    logic [15:0] bus_idle_ticks;
    logic [15:0] counting_ticks;
    logic [15:0] heartbeat_ticks;
    res_t        pending_actions[$];
    int          errors;

    function new();
      errors          = 0;
      role            = ROLE_READER;
      leader_id       = '0;
      voters          = '0;
      own_id          = OWN_ID_RST;
      bus_idle_ticks  = BUS_IDLE_RST;
      counting_ticks  = COUNTING_RST;
      heartbeat_ticks = HEARTBEAT_RST;
    endfunction

    function void note_config(logic [1:0] idx, logic [15:0] data);
      case (idx)
        CFG_OWN_ID:    own_id = data[5:0];
        CFG_BUS_IDLE:  bus_idle_ticks = data;
        CFG_COUNTING:  counting_ticks = data;
        CFG_HEARTBEAT: heartbeat_ticks = data;
        default: ;
      endcase
    endfunction

    function void push_action(logic [2:0] act, logic [1:0] tsel, logic [15:0] dly,
                              logic [5:0] dest, logic [1:0] msg, logic [5:0] param,
                              logic ign);
      res_t r;
      r.action        = act;
      r.timer_sel     = tsel;
      r.delay         = dly;
      r.dest_id       = dest;
      r.message       = msg;
      r.message_param = param;
      r.ignored       = ign;
      r.last          = 1'b0;
      pending_actions.push_back(r);
    endfunction

    function void fall_back_to_reader();
      push_action(A_CLEAR_ALL, T_BUSIDLE, '0, '0, M_HEARTBEAT, '0, 1'b0);
      push_action(A_ARM, T_BUSIDLE, bus_idle_ticks, '0, M_HEARTBEAT, '0, 1'b0);
      role      = ROLE_READER;
      leader_id = '0;
    endfunction

    // Lowest seen voter wins, but only with at least two voters on the bus
    function void tally_votes();
      int         count;
      logic [5:0] lowest;
      count  = 0;
      lowest = '0;
      for (int i = 0; i < 32 && i < VOTER_SLOTS; i++) begin
        if (voters[i]) begin
          count++;
          if (count == 1) lowest = 6'(i + 1);
        end
      end
      if (count > 1 && lowest == own_id) begin
        role = ROLE_LEADER;
        push_action(A_CLEAR_ALL, T_BUSIDLE, '0, '0, M_HEARTBEAT, '0, 1'b0);
        push_action(A_ARM, T_HEARTBEAT, heartbeat_ticks, '0, M_HEARTBEAT, '0, 1'b0);
      end else begin
        fall_back_to_reader();
      end
    endfunction

    function void note_event(logic [3:0] k, logic [5:0] sid, logic [15:0] draw);
      int          first;
      logic [15:0] rnd;
      logic        ign;
      res_t        tail;
      first = pending_actions.size();
      rnd   = 16'(draw % 16'd29) + 16'd1;
      ign   = 1'b0;
      case (role)
        ROLE_READER: begin
          if (k == K_STARTUP) begin
            push_action(A_CLEAR_ALL, T_BUSIDLE, '0, '0, M_HEARTBEAT, '0, 1'b0);
            push_action(A_ARM, T_BUSIDLE, bus_idle_ticks, '0, M_HEARTBEAT, '0, 1'b0);
          end else if (k == K_BUSIDLE) begin
            push_action(A_CLEAR_ALL, T_BUSIDLE, '0, '0, M_HEARTBEAT, '0, 1'b0);
            push_action(A_ARM, T_COUNTING, counting_ticks, '0, M_HEARTBEAT, '0, 1'b0);
            push_action(A_ARM, T_RANDOM, rnd, '0, M_HEARTBEAT, '0, 1'b0);
            voters = '0;
            role   = ROLE_VOTER;
          end else if (k == K_HEARTBEAT) begin
            if (sid <= leader_id || leader_id == '0) begin
              leader_id = sid;
              push_action(A_CLEAR_ONE, T_BUSIDLE, '0, '0, M_HEARTBEAT, '0, 1'b0);
              push_action(A_ARM, T_BUSIDLE, bus_idle_ticks, '0, M_HEARTBEAT, '0, 1'b0);
            end
          end else if (k == K_SENSOR) begin
            push_action(A_SEND, T_BUSIDLE, '0, leader_id, M_SENSOR, '0, 1'b0);
          end else begin
            ign = 1'b1;
          end
        end
        ROLE_VOTER: begin
          if (k == K_COUNTING) begin
            tally_votes();
          end else if (k == K_RANDOM) begin
            push_action(A_SEND, T_BUSIDLE, '0, '0, M_VOTING, own_id, 1'b0);
            push_action(A_ARM, T_RANDOM, rnd, '0, M_HEARTBEAT, '0, 1'b0);
          end else if (k == K_HEARTBEAT) begin
            fall_back_to_reader();
          end else if (k == K_SENSOR) begin
            // handled, nothing to do
          end else if (k == K_VOTING) begin
            if (sid >= 6'd1 && sid <= VOTER_SLOTS && sid <= 6'd32) begin
              if (!voters[sid - 6'd1]) begin
                voters[sid - 6'd1] = 1'b1;
                push_action(A_CLEAR_ONE, T_COUNTING, '0, '0, M_HEARTBEAT, '0, 1'b0);
                push_action(A_ARM, T_COUNTING, counting_ticks, '0, M_HEARTBEAT, '0, 1'b0);
              end
            end else begin
              ign = 1'b1;
            end
          end else begin
            ign = 1'b1;
          end
        end
        ROLE_LEADER: begin
          if (k == K_HBTMO) begin
            push_action(A_SEND, T_BUSIDLE, '0, '0, M_HEARTBEAT, own_id, 1'b0);
            push_action(A_ARM, T_HEARTBEAT, heartbeat_ticks, '0, M_HEARTBEAT, '0, 1'b0);
          end else if (k == K_HEARTBEAT) begin
            if (sid > own_id)
              push_action(A_SEND, T_BUSIDLE, '0, sid, M_WTF, '0, 1'b0);
          end else if (k == K_SENSOR) begin
            // handled, nothing to do
          end else if (k == K_WTF) begin
            fall_back_to_reader();
          end else begin
            ign = 1'b1;
          end
        end
        default: ign = 1'b1;
      endcase
      if (pending_actions.size() == first)
        push_action(A_NONE, T_BUSIDLE, '0, '0, M_HEARTBEAT, '0, ign);
      tail      = pending_actions.pop_back();
      tail.last = 1'b1;
      pending_actions.push_back(tail);
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        $error("%s: expected %0d, got %0d", field, want, got);
      end
    endfunction

    function void check_action(res_t got);
      res_t want;
      if (pending_actions.size() == 0) begin
        errors++;
        $error("action %0d arrived with nothing outstanding", got.action);
        return;
      end
      want = pending_actions.pop_front();
      compare("action", 16'(want.action), 16'(got.action));
      compare("timer_sel", 16'(want.timer_sel), 16'(got.timer_sel));
      compare("delay", want.delay, got.delay);
      compare("dest_id", 16'(want.dest_id), 16'(got.dest_id));
      compare("message", 16'(want.message), 16'(got.message));
      compare("message_param", 16'(want.message_param), 16'(got.message_param));
      compare("ignored", 16'(want.ignored), 16'(got.ignored));
      compare("last", 16'(want.last), 16'(got.last));
    endfunction
  endclass

endpackage

/* tb/bus_node_leader_election_tb.sv */
module bus_node_leader_election_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bnle_pkg::*;
  import bnle_tb_pkg::*;

  // Cycles without any transfer on any channel before the run is declared hung
  localparam int QUIET_LIMIT  = 1000;
  // Settle time after the last expected action (two-stage pipeline plus margin)
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASES       = 6;
  localparam int PHASE_EVENTS = 75;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [3:0]  kind;
  logic [5:0]  sender_id;
  logic [15:0] random_draw;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  action;
  logic [1:0]  timer_sel;
  logic [15:0] delay;
  logic [5:0]  dest_id;
  logic [1:0]  message;
  logic [5:0]  message_param;
  logic        ignored;
  logic        last;

  election_scoreboard sb;

  // Idle modes: when off, that side runs back to back
  logic tx_idles;
  logic rx_stalls;
  int   stall_left;
  int   action_count;
  int   quiet;

  bus_node_leader_election #(
    .NODES(VOTER_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .sender_id(sender_id),
    .random_draw(random_draw),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .action(action),
    .timer_sel(timer_sel),
    .delay(delay),
    .dest_id(dest_id),
    .message(message),
    .message_param(message_param),
    .ignored(ignored),
    .last(last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: drop ready for the drawn number of cycles after each transfer
  always @(negedge clk) begin
    if (rst || stall_left != 0) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
    if (!rst && stall_left != 0) stall_left <= stall_left - 1;
  end

  // Check every action transfer against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_action({action, timer_sel, delay, dest_id, message, message_param,
                       ignored, last});
      action_count <= action_count + 1;
      // Switch receiver mode now and then so runs with and without stalls occur
      if (action_count % 40 == 39) rx_stalls <= 1'($urandom_range(0, 1));
      stall_left <= rx_stalls ? $urandom_range(0, 3) : 0;
    end
  end

  // Watchdog: any transfer resets the quiet counter
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("FAIL bus_node_leader_election");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Present one event, hold it until the transfer, then predict its actions.
  // Valid stays high past the transfer only until the next falling edge, where
  // the caller either presents a new event or drops it.
  task automatic send_event(logic [3:0] k, logic [5:0] s, logic [15:0] d);
    int gap;
    gap = tx_idles ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    = 1'b1;
    kind        = k;
    sender_id   = s;
    random_draw = d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_event(k, s, d);
    @(negedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [15:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.note_config(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Stop sending and hold until every predicted action has come out
  task automatic drain_events();
    in_valid = 1'b0;
    while (sb.pending_actions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Pick an event that fits the predicted role most of the time, so that
  // elections complete and the leader role gets exercised; the rest is noise.
  task automatic random_event();
    int          pick;
    logic [3:0]  k;
    logic [5:0]  s;
    logic [15:0] d;
    int          own;
    pick = $urandom_range(0, 99);
    k    = 4'($urandom_range(0, 15));
    s    = 6'($urandom_range(0, 63));
    d    = 16'($urandom_range(0, 65535));
    own  = int'(sb.own_id);
    case (sb.role)
      ROLE_READER: begin
        if (pick < 35) k = K_BUSIDLE;
        else if (pick < 55) k = K_HEARTBEAT;
        else if (pick < 68) k = K_SENSOR;
        else if (pick < 78) k = K_STARTUP;
      end
      ROLE_VOTER: begin
        if (pick < 50) begin
          k = K_VOTING;
          // Favor our own id and ids above it, so we are often the lowest
          case ($urandom_range(0, 9))
            0, 1, 2:          s = 6'(own);
            3, 4, 5, 6, 7:    s = 6'($urandom_range((own >= 1 && own <= 32) ? own : 1, 32));
            8:                s = 6'($urandom_range(1, 32));
            default:          s = 6'($urandom_range(0, 63));
          endcase
        end else if (pick < 62) begin
          k = K_RANDOM;
        end else if (pick < 77) begin
          k = K_COUNTING;
        end else if (pick < 82) begin
          k = K_HEARTBEAT;
        end else if (pick < 87) begin
          k = K_SENSOR;
        end
      end
      default: begin
        if (pick < 30) k = K_HBTMO;
        else if (pick < 55) k = K_HEARTBEAT;
        else if (pick < 65) k = K_SENSOR;
        else if (pick < 75) k = K_WTF;
      end
    endcase
    send_event(k, s, d);
  endtask

  initial begin
    logic [5:0]  own;
    logic [15:0] ticks_b;
    logic [15:0] ticks_c;
    logic [15:0] ticks_h;

    sb           = new();
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_OWN_ID;
    cfg_data     = '0;
    in_valid     = 1'b0;
    kind         = K_STARTUP;
    sender_id    = '0;
    random_draw  = '0;
    out_ready    = 1'b0;
    tx_idles     = 1'b1;
    rx_stalls    = 1'b1;
    stall_left   = 0;
    action_count = 0;
    quiet        = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed walk with reset registers (own id 1): reader, voter, leader, back
    send_event(K_STARTUP, 6'd0, 16'd0);         // clear all, arm bus idle
    send_event(K_SENSOR, 6'd5, 16'd0);          // no leader known: broadcast
    send_event(K_HEARTBEAT, 6'd0, 16'd0);       // heartbeat from id zero taken
    send_event(K_HEARTBEAT, 6'd20, 16'd0);      // first real leader
    send_event(K_HEARTBEAT, 6'd30, 16'd0);      // higher id: no action
    send_event(K_SENSOR, 6'd0, 16'd0);          // forward to leader 20
    send_event(4'd15, 6'd63, 16'hFFFF);         // kind above the last one
    send_event(K_HBTMO, 6'd0, 16'd0);           // not handled in reader
    send_event(K_BUSIDLE, 6'd0, 16'hFFFF);      // enter voter, largest draw
    send_event(K_VOTING, 6'd0, 16'd0);          // vote id zero
    send_event(K_VOTING, 6'd33, 16'd0);         // vote id past the bitmap
    send_event(K_VOTING, 6'd63, 16'd0);
    send_event(K_VOTING, 6'd1, 16'd0);
    send_event(K_VOTING, 6'd1, 16'd0);          // repeated vote: no action
    send_event(K_VOTING, 6'd32, 16'd0);
    send_event(K_RANDOM, 6'd0, 16'd0);          // smallest draw
    send_event(K_SENSOR, 6'd0, 16'd0);          // handled, no action
    send_event(K_STARTUP, 6'd0, 16'd0);         // not handled in voter
    send_event(K_COUNTING, 6'd0, 16'd0);        // two voters, we are lowest
    send_event(K_HBTMO, 6'd0, 16'd0);
    send_event(K_HEARTBEAT, 6'd1, 16'd0);       // equal id: no action
    send_event(K_HEARTBEAT, 6'd40, 16'd0);      // higher id: answer wtf
    send_event(K_SENSOR, 6'd0, 16'd0);
    send_event(K_BUSIDLE, 6'd0, 16'd0);         // not handled in leader
    send_event(K_WTF, 6'd0, 16'd0);             // step down

    for (int ph = 0; ph < PHASES; ph++) begin
      // Registers change only with nothing in flight
      drain_events();
      ticks_b = 16'($urandom_range(1, 65535));
      ticks_c = 16'($urandom_range(1, 65535));
      ticks_h = 16'($urandom_range(1, 65535));
      case (ph)
        0: begin
          own = 6'd1;
          ticks_b = 16'd1;
          ticks_c = 16'd1;
          ticks_h = 16'd1;
        end
        1: begin
          own = 6'd32;
          ticks_b = 16'hFFFF;
          ticks_c = 16'hFFFF;
          ticks_h = 16'hFFFF;
        end
        2: own = 6'($urandom_range(1, 4));
        3: own = 6'd63;
        4: own = 6'($urandom_range(1, 32));
        default: begin
          own = 6'd0;
          ticks_b = 16'd0;
          ticks_c = 16'd0;
          ticks_h = 16'd0;
        end
      endcase
      // Upper data bits are junk for the id register
      write_register(CFG_OWN_ID, {10'($urandom), own});
      write_register(CFG_BUS_IDLE, ticks_b);
      write_register(CFG_COUNTING, ticks_c);
      write_register(CFG_HEARTBEAT, ticks_h);
      tx_idles = 1'($urandom_range(0, 1));

      for (int n = 0; n < PHASE_EVENTS; n++) begin
        // Occasionally hold off until the block has emptied out
        if ($urandom_range(0, 39) == 0) drain_events();
        random_event();
      end
    end

    drain_events();
    repeat (2 * DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_actions.size() == 0) begin
      $display("PASS bus_node_leader_election");
    end else begin
      $display("FAIL bus_node_leader_election");
    end
    $finish;
  end

endmodule
